[design/utic_pkg.sv]
`default_nettype none

package utic_pkg;

    localparam int ORDER_BITS = 16;
    localparam int INDEX_BITS = 31;
    localparam int COORD_BITS = 16;
    localparam int ROOT_BITS = 36;

    localparam int SQRT_FIRST = 3;
    localparam int SQRT_STAGES = 6;
    localparam int SQRT_STEPS = 3;
    localparam int SQRT_TOP_SHIFT = 2 * (SQRT_STAGES * SQRT_STEPS - 1);
    localparam int NUM_STAGES = SQRT_FIRST + SQRT_STAGES + 3;

    typedef struct packed {
        logic [INDEX_BITS-1:0]   k;
        logic [ORDER_BITS-1:0]   n;
        logic [2*ORDER_BITS:0]   total;
        logic [2*ORDER_BITS+1:0] bb;
        logic                    err;
        logic [ROOT_BITS-1:0]    v;
        logic [ROOT_BITS-1:0]    root;
        logic [COORD_BITS-1:0]   row;
        logic [ORDER_BITS-1:0]   m;
        logic [2*ORDER_BITS-1:0] mn;
        logic [2*ORDER_BITS-1:0] mm;
        logic [COORD_BITS-1:0]   column;
    } pipe_t;

    typedef struct packed {
        logic [ROOT_BITS-1:0] v;
        logic [ROOT_BITS-1:0] root;
    } sqrt_t;

    // One restoring square-root step.
    function automatic sqrt_t sqrt_step(input sqrt_t cur, input logic [ROOT_BITS-1:0] bitv);
        sqrt_t                res;
        logic [ROOT_BITS-1:0] trial;
        trial = cur.root + bitv;
        if (cur.v >= trial)
        begin
            res.v = cur.v - trial;
            res.root = (cur.root >> 1) + bitv;
        end
        else
        begin
            res.v = cur.v;
            res.root = cur.root >> 1;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

[design/upper_triangle_index_to_coord.sv]
`default_nettype none
// Throughput: one index per cycle unless the output stalls; the floor square root
// is split over six stages of three bit steps each, with multiplies before and after.
// Stalls ripple back only through occupied stages; bubbles are filled.
// Reset clears all valid bits and sets triangle_order to 1.
module upper_triangle_index_to_coord (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,   // triangle_order
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,  // [30:0] linear_index
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,  // [15:0] row, [31:16] column
    output logic             m_axis_tuser   // index_error
);
    import utic_pkg::*;

    logic [ORDER_BITS-1:0] triangle_order_reg;
    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] adv;
    pipe_t                 stage_reg  [NUM_STAGES];
    pipe_t                 stage_next [NUM_STAGES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            triangle_order_reg <= ORDER_BITS'(1);
        end
        else if (cfg_wr_en)
        begin
            triangle_order_reg <= cfg_wr_data[ORDER_BITS-1:0];
        end
    end

    always_comb
    begin
        adv[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || m_axis_tready;
        for (int i = NUM_STAGES - 2; i >= 0; i--)
        begin
            adv[i] = !valid_reg[i] || adv[i+1];
        end
    end

    assign s_axis_tready = adv[0];

    always_comb
    begin
        pipe_t                   st;
        sqrt_t                   sq;
        logic [ORDER_BITS:0]     b;
        logic [ORDER_BITS+1:0]   twice;
        logic [2*ORDER_BITS-1:0] rb;
        logic [2*ORDER_BITS-1:0] j;

        // input capture
        st = stage_reg[0];
        st.k = s_axis_tdata[INDEX_BITS-1:0];
        st.n = triangle_order_reg;
        stage_next[0] = st;

        // n(n+1) and B*B
        st = stage_reg[0];
        b = {st.n, 1'b1};
        st.total = (2*ORDER_BITS+1)'(st.n) * (2*ORDER_BITS+1)'({1'b0, st.n} + 1'b1);
        st.bb = (2*ORDER_BITS+2)'(b) * (2*ORDER_BITS+2)'(b);
        stage_next[1] = st;

        // range check and D = B*B - 8k
        st = stage_reg[1];
        st.err = (st.k == '0) || ({2'b00, st.k} > (st.total >> 1));
        st.v = ROOT_BITS'(st.bb - {st.k, 3'b000});
        st.root = '0;
        stage_next[2] = st;

        for (int s = 0; s < SQRT_STAGES; s++)
        begin
            st = stage_reg[SQRT_FIRST-1+s];
            sq.v = st.v;
            sq.root = st.root;
            for (int t = 0; t < SQRT_STEPS; t++)
            begin
                sq = sqrt_step(sq, ROOT_BITS'(1) << (SQRT_TOP_SHIFT - 2 * (s * SQRT_STEPS + t)));
            end
            st.v = sq.v;
            st.root = sq.root;
            stage_next[SQRT_FIRST+s] = st;
        end

        // row = ceil((B - s) / 2)
        st = stage_reg[SQRT_FIRST+SQRT_STAGES-1];
        b = {st.n, 1'b1};
        twice = (ORDER_BITS+2)'(b) - st.root[ORDER_BITS+1:0] + 1'b1;
        st.row = twice[COORD_BITS:1];
        st.m = twice[ORDER_BITS:1] - 1'b1;
        stage_next[SQRT_FIRST+SQRT_STAGES] = st;

        // K(m) partial products
        st = stage_reg[SQRT_FIRST+SQRT_STAGES];
        st.mn = (2*ORDER_BITS)'(st.m) * (2*ORDER_BITS)'(st.n);
        st.mm = (2*ORDER_BITS)'(st.m) * (2*ORDER_BITS)'(st.m - 1'b1);
        stage_next[SQRT_FIRST+SQRT_STAGES+1] = st;

        // column and error zeroing
        st = stage_reg[SQRT_FIRST+SQRT_STAGES+1];
        rb = st.mn - (st.mm >> 1);
        j = (2*ORDER_BITS)'(st.m) + (2*ORDER_BITS)'(st.k) - rb;
        st.column = st.err ? '0 : j[COORD_BITS-1:0];
        st.row = st.err ? '0 : st.row;
        stage_next[NUM_STAGES-1] = st;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                valid_reg[0] <= s_axis_tvalid;
            end
            for (int i = 1; i < NUM_STAGES; i++)
            begin
                if (adv[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NUM_STAGES; i++)
        begin
            if (adv[i])
            begin
                stage_reg[i] <= stage_next[i];
            end
        end
    end

    assign m_axis_tvalid = valid_reg[NUM_STAGES-1];
    assign m_axis_tdata  = {stage_reg[NUM_STAGES-1].column, stage_reg[NUM_STAGES-1].row};
    assign m_axis_tuser  = stage_reg[NUM_STAGES-1].err;

`ifndef ASSERT_OFF
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 32'd0)
        else $error("error result with nonzero coordinates");

    a_coord_order: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |->
            m_axis_tdata[15:0] != 16'd0 && m_axis_tdata[31:16] >= m_axis_tdata[15:0])
        else $error("row zero or column below row");

    a_within_order: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[31:16] <= triangle_order_reg)
        else $error("column beyond matrix order");

    a_full_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> &valid_reg)
        else $error("input stalled while pipeline has a bubble");
`endif

endmodule

`default_nettype wire

[verif/testbench.sv]
module testbench;

    import utic_pkg::*;

    localparam int PIPE_LATENCY = 12;
    localparam int NUM_PHASES   = 11;
    localparam int PHASE_ITEMS  = 50;
    localparam int LONG_HOLD    = 60;

    typedef struct {
        bit [15:0] row;
        bit [15:0] column;
        bit        err;
    } coord_t;

    typedef struct {
        bit [15:0] order;
        bit [30:0] k;
        bit        known;
        bit [15:0] row;
        bit [15:0] column;
        bit        err;
    } probe_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tuser;

    coord_t      expected_coords[$];
    bit   [15:0] order_reg;
    int          mismatches;
    int          sent_count;
    bit          sending;
    bit          quiet;
    bit          held_long;

    probe_t probes [25] = '{
        '{16'd1,     31'd0,          1'b1, 16'd0,     16'd0,     1'b1},
        '{16'd1,     31'd1,          1'b1, 16'd1,     16'd1,     1'b0},
        '{16'd1,     31'd2,          1'b1, 16'd0,     16'd0,     1'b1},
        '{16'd1,     31'h7FFF_FFFF,  1'b1, 16'd0,     16'd0,     1'b1},
        '{16'd0,     31'd1,          1'b1, 16'd0,     16'd0,     1'b1},
        '{16'd0,     31'h7FFF_FFFF,  1'b1, 16'd0,     16'd0,     1'b1},
        '{16'd4,     31'd1,          1'b1, 16'd1,     16'd1,     1'b0},
        '{16'd4,     31'd4,          1'b1, 16'd1,     16'd4,     1'b0},
        '{16'd4,     31'd5,          1'b1, 16'd2,     16'd2,     1'b0},
        '{16'd4,     31'd7,          1'b1, 16'd2,     16'd4,     1'b0},
        '{16'd4,     31'd8,          1'b0, 16'd0,     16'd0,     1'b0},
        '{16'd4,     31'd10,         1'b1, 16'd4,     16'd4,     1'b0},
        '{16'd4,     31'd11,         1'b1, 16'd0,     16'd0,     1'b1},
        '{16'd3,     31'd6,          1'b1, 16'd3,     16'd3,     1'b0},
        '{16'd65535, 31'd1,          1'b1, 16'd1,     16'd1,     1'b0},
        '{16'd65535, 31'd65535,      1'b1, 16'd1,     16'd65535, 1'b0},
        '{16'd65535, 31'd65536,      1'b1, 16'd2,     16'd2,     1'b0},
        '{16'd65535, 31'd2147450879, 1'b1, 16'd65534, 16'd65535, 1'b0},
        '{16'd65535, 31'd2147450880, 1'b1, 16'd65535, 16'd65535, 1'b0},
        '{16'd65535, 31'd2147450881, 1'b1, 16'd0,     16'd0,     1'b1},
        '{16'd65535, 31'h7FFF_FFFF,  1'b1, 16'd0,     16'd0,     1'b1},
        '{16'd65535, 31'd0,          1'b1, 16'd0,     16'd0,     1'b1},
        '{16'd65535, 31'd1234567890, 1'b0, 16'd0,     16'd0,     1'b0},
        '{16'd65535, 31'h4000_0000,  1'b0, 16'd0,     16'd0,     1'b0},
        '{16'd1000,  31'd500500,     1'b1, 16'd1000,  16'd1000,  1'b0}
    };

    upper_triangle_index_to_coord u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    function automatic longint unsigned active_order();
        return longint'(order_reg) & ((64'd1 << ORDER_BITS) - 64'd1);
    endfunction

    // elements in the first m rows of an order-n triangle
    function automatic longint unsigned rows_filled(longint unsigned m, longint unsigned n);
        if (m == 0)
            return 0;
        return m * n - ((m * (m - 1)) >> 1);
    endfunction

    function automatic longint unsigned floor_root(longint unsigned v);
        longint unsigned r;
        longint unsigned c;
        r = 0;
        for (int b = 20; b >= 0; b--)
        begin
            c = r | (64'd1 << b);
            if (c * c <= v)
                r = c;
        end
        return r;
    endfunction

    function automatic coord_t locate_element(bit [30:0] idx);
        coord_t          res;
        longint unsigned n;
        longint unsigned k;
        longint unsigned total;
        longint unsigned b;
        longint unsigned s;
        longint unsigned i;
        longint unsigned j;
        n = active_order();
        k = longint'(idx);
        total = (n * (n + 1)) >> 1;
        res = '{16'd0, 16'd0, 1'b1};
        if (k != 0 && k <= total)
        begin
            b = 2 * n + 1;
            s = floor_root(b * b - 8 * k);
            i = ((b - s + 1) & ~64'd1) >> 1;
            j = (i - 1) + k - rows_filled(i - 1, n);
            res.row = i[15:0];
            res.column = j[15:0];
            res.err = 1'b0;
        end
        return res;
    endfunction

    function automatic bit [30:0] pick_index();
        longint unsigned n;
        longint unsigned total;
        longint unsigned r;
        int              p;
        n = active_order();
        total = (n * (n + 1)) >> 1;
        p = $urandom_range(0, 99);
        if (total == 0 || p >= 88)
            return 31'($urandom());
        if (p < 60)
            return 31'($urandom_range(32'(total), 1));
        if (p < 78)
        begin
            r = $urandom_range(32'(n), 1);
            if ($urandom_range(0, 1) == 0)
                return 31'(rows_filled(r - 1, n) + 1);
            return 31'(rows_filled(r, n));
        end
        case ($urandom_range(0, 3))
            0: return 31'd0;
            1: return 31'd1;
            2: return 31'(total);
            default: return 31'(total + 1);
        endcase
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // call at a falling edge; returns at a falling edge
    task automatic send_index(input bit [30:0] k, input coord_t want);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {1'b0, k};
        do
            @(posedge clk);
        while (!s_axis_tready);
        expected_coords.push_back(want);
        sent_count++;
        @(negedge clk);
    endtask

    task automatic set_order(input bit [15:0] value);
        s_axis_tvalid <= 1'b0;
        while (expected_coords.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 2) @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        order_reg = value;
    endtask

    // receiver side: short random stalls plus one long hold-off under load
    initial
    begin : sink_ready
        int gap;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!held_long && sending && sent_count >= 150)
            begin
                held_long = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge clk);
            end
            else if (!quiet && $urandom_range(0, 4) == 0)
            begin
                gap = $urandom_range(1, 9);
                m_axis_tready <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        coord_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_coords.size() == 0)
                report_mismatch("unexpected transfer", m_axis_tdata, 0);
            else
            begin
                want = expected_coords.pop_front();
                if (m_axis_tdata[15:0] !== want.row)
                    report_mismatch("row", m_axis_tdata[15:0], want.row);
                if (m_axis_tdata[31:16] !== want.column)
                    report_mismatch("column", m_axis_tdata[31:16], want.column);
                if (m_axis_tuser !== want.err)
                    report_mismatch("index_error", m_axis_tuser, want.err);
            end
        end
    end

    initial
    begin
        #(12 * 300000);
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin : stimulus
        bit [15:0] phase_orders [NUM_PHASES];
        bit [30:0] k;
        coord_t    want;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = 16'd0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = 32'd0;
        order_reg = 16'd1;
        mismatches = 0;
        sent_count = 0;
        sending = 1'b0;
        quiet = 1'b0;
        held_long = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (probes[r])
        begin
            if (probes[r].order != order_reg)
                set_order(probes[r].order);
            if (probes[r].known)
                want = '{probes[r].row, probes[r].column, probes[r].err};
            else
                want = locate_element(probes[r].k);
            send_index(probes[r].k, want);
        end

        phase_orders = '{16'd1, 16'd65535, 16'd0, 16'd2, 16'($urandom_range(3, 20)),
                         16'($urandom_range(21, 300)), 16'($urandom_range(1, 65535)),
                         16'd65534, 16'($urandom_range(1, 65535)),
                         16'($urandom_range(1, 1000)), 16'd65535};
        foreach (phase_orders[p])
        begin
            set_order(phase_orders[p]);
            quiet = (p == NUM_PHASES - 1);
            sending = 1'b1;
            repeat (PHASE_ITEMS)
            begin
                k = pick_index();
                send_index(k, locate_element(k));
            end
            sending = 1'b0;
        end
        s_axis_tvalid <= 1'b0;

        while (expected_coords.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 8) @(posedge clk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[files.f]
design/utic_pkg.sv
design/upper_triangle_index_to_coord.sv
verif/testbench.sv
